// File: src/pidp_pkg.sv
// ----------------------------------------------------------------------------
// Packed int8 dot product package
// Shared constants and types for the packed int8 dot product core.
// ----------------------------------------------------------------------------
`default_nettype none

package pidp_pkg;

  // Number of 16-bit weight slots used from each weight word.
  localparam int DEFAULT_LANES = 4;

  // Snapshots of the accumulator bank that may wait for the result side.
  localparam int QUEUE_DEPTH = 2;

  localparam int SUM_W           = 32;
  localparam int PROD_W          = 16;
  localparam int SCALE_W         = 32;
  localparam int SCALE_FRAC_BITS = 24;

  // Scale of 1.0 in unsigned fixed point with 24 fraction bits.
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0100_0000;

  typedef logic [SUM_W-1:0] sum_t;

  // Fill status of the snapshot queue, seen by both sides.
  typedef struct packed {
    logic nonempty;
    logic full;
  } queue_status_t;

endpackage : pidp_pkg

`default_nettype wire

// File: src/pidp_ifs.sv
// ----------------------------------------------------------------------------
// Packed int8 dot product channels
// Valid/ready channels for input items, results and the scale register.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidp_item_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] activation;
  logic [63:0]       weight_word;
  logic              last_item;

  modport source (output valid, activation, weight_word, last_item, input ready);
  modport sink   (input valid, activation, weight_word, last_item, output ready);
endinterface : pidp_item_if

interface pidp_result_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] result_value;
  logic [2:0]        result_index;
  logic              last_result;

  modport source (output valid, result_value, result_index, last_result, input ready);
  modport sink   (input valid, result_value, result_index, last_result, output ready);
endinterface : pidp_result_if

interface pidp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface : pidp_cfg_if

`default_nettype wire

// File: src/packed_int8_dot_product_requant_core.sv
// ----------------------------------------------------------------------------
// Packed int8 dot product requantization core
// Dual int8 packed multiply-accumulate with a fixed-point int8 output stage.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel takes one request per cycle: a signed activation, a word
//   of LANES 16-bit slots holding two int8 weights each, and a last flag.
//   Every lane adds activation*low and activation*high into two 32-bit
//   wrapping accumulators. A request with last set closes the dot product:
//   its own products are included, the bank is copied into a two-entry
//   snapshot queue and the accumulators clear for the next dot product.
//   The result channel then delivers 2*LANES requests, one per cycle while
//   result ready holds, in the order low sum then high sum of lane 0, then
//   lane 1 and so on; each is the sum times output_scale (24 fraction bits),
//   truncated toward zero and wrapped to 8 bits. last_result marks the
//   final request of each burst. Throughput is one item per cycle. Results
//   pass stages a and b and the output register. Item ready drops only when
//   a closing item finds both snapshots still waiting for the result side,
//   so a stalled receiver backs up through the queue and then the front.
//   The cfg channel writes output_scale and is always ready; write it only
//   while the block is idle. Reset clears all accumulators, empties the
//   queue and sets the scale to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_int8_dot_product_requant_core #(
  parameter int LANES = pidp_pkg::DEFAULT_LANES
) (
  input  logic          clk,
  input  logic          rst,
  pidp_item_if.sink     item,
  pidp_result_if.source result,
  pidp_cfg_if.sink      cfg
);
  import pidp_pkg::*;

  // Scale register: written from the cfg channel, read by the result side.
  logic [SCALE_W-1:0]   output_scale;

  // Snapshot traffic between the accumulator side and the result side.
  queue_status_t        q_status;
  logic                 push;
  logic                 pop;
  sum_t [2*LANES-1:0]   push_sums;
  sum_t [2*LANES-1:0]   head_sums;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_scale <= SCALE_RESET;
    end else if (cfg.valid) begin
      output_scale <= cfg.data;
    end
  end

  // Front: packed multiplies and accumulation, one item per cycle while not stalled.
  pidp_front #(
    .LANES (LANES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .q_status  (q_status),
    .push      (push),
    .push_sums (push_sums)
  );

  // Queue: lets a burst drain while the next dot product accumulates.
  pidp_queue #(
    .LANES (LANES),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_sums (push_sums),
    .pop       (pop),
    .head_sums (head_sums),
    .status    (q_status)
  );

  // Back: serializes the snapshot and requantizes each sum.
  pidp_back #(
    .LANES (LANES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .scale     (output_scale),
    .head_sums (head_sums),
    .q_status  (q_status),
    .pop       (pop),
    .result    (result)
  );

endmodule : packed_int8_dot_product_requant_core

`default_nettype wire

// File: src/pidp_front.sv
// ----------------------------------------------------------------------------
// Packed int8 dot product front end
// Packed lane multiplies and the wrapping accumulator bank.
// ----------------------------------------------------------------------------
`default_nettype none

module pidp_front #(
  parameter int LANES = pidp_pkg::DEFAULT_LANES
) (
  input  logic                        clk,
  input  logic                        rst,
  pidp_item_if.sink                   item,
  input  pidp_pkg::queue_status_t     q_status,
  output logic                        push,
  output pidp_pkg::sum_t [2*LANES-1:0] push_sums
);
  import pidp_pkg::*;

  logic                    stall;
  logic                    s1_valid;
  logic                    s1_last;
  logic [PROD_W-1:0]       s1_lo [LANES];
  logic [PROD_W-1:0]       s1_hi [LANES];
  logic [PROD_W-1:0]       lo_prod [LANES];
  logic [PROD_W-1:0]       hi_prod [LANES];
  sum_t                    acc_lo [LANES];
  sum_t                    acc_hi [LANES];
  sum_t                    sum_lo [LANES];
  sum_t                    sum_hi [LANES];

  // A last request that finds the queue full holds in stage one.
  assign stall      = s1_valid && s1_last && q_status.full;
  assign item.ready = !stall;
  assign push       = s1_valid && s1_last && !q_status.full;

  for (genvar n = 0; n < LANES; n++) begin : g_lane
    logic signed [7:0]  w_hi;
    logic signed [7:0]  w_lo;
    logic signed [24:0] packed_w;
    logic [31:0]        act_ext;
    logic [31:0]        w_ext;
    logic [31:0]        p;

    assign w_hi     = item.weight_word[16*n+8 +: 8];
    assign w_lo     = item.weight_word[16*n +: 8];
    assign packed_w = $signed({w_hi[7], w_hi, 16'h0000}) + $signed({{17{w_lo[7]}}, w_lo});
    assign act_ext  = {{24{item.activation[7]}}, item.activation};
    assign w_ext    = {{7{packed_w[24]}}, packed_w};
    // Only the low 32 bits of the packed product are needed.
    assign p        = act_ext * w_ext;
    assign lo_prod[n] = p[15:0];
    // The high half borrows one when the low product is negative.
    assign hi_prod[n] = p[31:16] + {15'b0, p[15]};

    assign sum_lo[n] = acc_lo[n] + {{(SUM_W-PROD_W){s1_lo[n][PROD_W-1]}}, s1_lo[n]};
    assign sum_hi[n] = acc_hi[n] + {{(SUM_W-PROD_W){s1_hi[n][PROD_W-1]}}, s1_hi[n]};
    assign push_sums[2*n]   = sum_lo[n];
    assign push_sums[2*n+1] = sum_hi[n];

    always_ff @(posedge clk) begin
      if (!stall) begin
        s1_lo[n] <= lo_prod[n];
        s1_hi[n] <= hi_prod[n];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        acc_lo[n] <= '0;
        acc_hi[n] <= '0;
      end else if (s1_valid && !stall) begin
        acc_lo[n] <= s1_last ? '0 : sum_lo[n];
        acc_hi[n] <= s1_last ? '0 : sum_hi[n];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_last <= item.last_item;
    end
  end

endmodule : pidp_front

`default_nettype wire

// File: src/pidp_queue.sv
// ----------------------------------------------------------------------------
// Packed int8 dot product snapshot queue
// Short queue of finished accumulator banks between the two sides.
// ----------------------------------------------------------------------------
`default_nettype none

module pidp_queue #(
  parameter int LANES = pidp_pkg::DEFAULT_LANES,
  parameter int DEPTH = pidp_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  pidp_pkg::sum_t [2*LANES-1:0] push_sums,
  input  logic                         pop,
  output pidp_pkg::sum_t [2*LANES-1:0] head_sums,
  output pidp_pkg::queue_status_t      status
);
  import pidp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sum_t [2*LANES-1:0] entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign status.nonempty = (count != '0);
  assign status.full     = (count == CNT_W'(DEPTH));
  assign head_sums       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_sums;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    status.full |-> !(push && !pop))
    else $error("snapshot queue written while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    pop |-> status.nonempty)
    else $error("snapshot queue read while empty");

endmodule : pidp_queue

`default_nettype wire

// File: src/pidp_back.sv
// ----------------------------------------------------------------------------
// Packed int8 dot product back end
// Walks a snapshot one sum at a time and requantizes it to int8.
// ----------------------------------------------------------------------------
`default_nettype none

module pidp_back #(
  parameter int LANES = pidp_pkg::DEFAULT_LANES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pidp_pkg::SCALE_W-1:0] scale,
  input  pidp_pkg::sum_t [2*LANES-1:0] head_sums,
  input  pidp_pkg::queue_status_t      q_status,
  output logic                         pop,
  pidp_result_if.source                result
);
  import pidp_pkg::*;

  localparam int              NRES     = 2 * LANES;
  localparam int              SEL_W    = $clog2(NRES);
  localparam logic [SEL_W-1:0] LAST_SEL = SEL_W'(NRES - 1);

  logic                      adv;
  logic                      take;
  logic [SEL_W-1:0]          sel;
  sum_t                      head;
  logic                      a_valid;
  logic                      a_neg;
  sum_t                      a_mag;
  logic [SEL_W-1:0]          a_idx;
  logic                      a_last;
  logic [SUM_W+SCALE_W-1:0]  prod;
  logic                      b_valid;
  logic                      b_neg;
  logic [7:0]                b_q8;
  logic [SEL_W-1:0]          b_idx;
  logic                      b_last;

  // The whole pipe moves while the output register is free or drained.
  assign adv  = !result.valid || result.ready;
  assign take = adv && q_status.nonempty;
  assign pop  = take && (sel == LAST_SEL);
  assign head = head_sums[sel];
  assign prod = {{SCALE_W{1'b0}}, a_mag} * {{SUM_W{1'b0}}, scale};

  always_ff @(posedge clk) begin
    if (rst) begin
      sel           <= '0;
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      result.valid  <= 1'b0;
    end else if (adv) begin
      if (take) begin
        sel <= (sel == LAST_SEL) ? '0 : sel + 1'b1;
      end
      a_valid      <= take;
      b_valid      <= a_valid;
      result.valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_neg  <= head[SUM_W-1];
      a_mag  <= head[SUM_W-1] ? (~head + 1'b1) : head;
      a_idx  <= sel;
      a_last <= (sel == LAST_SEL);
      // Truncation toward zero works on the magnitude; only 8 bits survive.
      b_q8   <= prod[SCALE_FRAC_BITS +: 8];
      b_neg  <= a_neg;
      b_idx  <= a_idx;
      b_last <= a_last;
      result.result_value <= b_neg ? (~b_q8 + 1'b1) : b_q8;
      result.result_index <= 3'(b_idx);
      result.last_result  <= b_last;
    end
  end

  a_last_is_final_index : assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.last_result) |-> (result.result_index == 3'(NRES - 1)))
    else $error("burst closed on the wrong result index");

  a_sel_idle_at_zero : assert property (@(posedge clk) disable iff (rst)
    !q_status.nonempty |-> (sel == '0))
    else $error("result walk left mid-snapshot with an empty queue");

endmodule : pidp_back

`default_nettype wire
